FILE: design/mcc_pkg.sv
// Shared widths, constants and register codes for the metric circumcenter core.
`timescale 1ns / 1ps
`default_nettype none

package mcc_pkg;

    // Field and limb widths
    localparam int COORD_W   = 32;
    localparam int LIMB_W    = 32;

    // Datapath widths, exact at every step
    localparam int U_W       = COORD_W + 1;          // vertex difference
    localparam int M1_W      = COORD_W + U_W;        // metric * difference
    localparam int X_W       = M1_W + 2;             // x12, x13, y12, y13
    localparam int SQ_W      = 2 * COORD_W;          // coordinate products
    localparam int M2_W      = COORD_W + SQ_W;       // metric * coordinate product
    localparam int K_W       = M2_W + 3;             // metric norm of a vertex
    localparam int E_W       = K_W + 1;              // d1, d2
    localparam int DET_W     = 2 * X_W + 1;          // determinant
    localparam int NUM_W     = E_W + X_W + 1;        // Cramer numerators

    // Pipeline latencies
    localparam int MUL_LAT   = 3;
    localparam int DIV_LAT   = COORD_W + 2;

    // Configuration
    localparam int THR_W         = 63;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_IDX_LSB   = 3;
    localparam int CFG_IDX_W     = CFG_ADDR_W - CFG_IDX_LSB;
    localparam logic [CFG_IDX_W-1:0] REG_DET_THRESHOLD = CFG_IDX_W'(0);

    // Saturation bounds
    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: design/mcc_if.sv
// Valid/ready channel interfaces for triangle input and circumcenter result.
`timescale 1ns / 1ps
`default_nettype none

interface mcc_in_if
    import mcc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] metric_xx;
    logic signed [COORD_W-1:0] metric_xy;
    logic signed [COORD_W-1:0] metric_yy;

    modport source (
        output valid, ax, ay, bx, by_coord, cx, cy, metric_xx, metric_xy, metric_yy,
        input  ready
    );
    modport sink (
        input  valid, ax, ay, bx, by_coord, cx, cy, metric_xx, metric_xy, metric_yy,
        output ready
    );
endinterface

interface mcc_out_if
    import mcc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic                      degenerate;
    logic                      overflow;

    modport source (
        output valid, center_x, center_y, degenerate, overflow,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, degenerate, overflow,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/mcc_mul.sv
// Pipelined signed multiplier built from 33x33 limb products, three register stages.
`timescale 1ns / 1ps
`default_nettype none

module mcc_mul
    import mcc_pkg::*;
#(
    parameter int A_W = COORD_W,
    parameter int B_W = COORD_W
)
(
    input  logic                      clk,
    input  logic                      adv,
    input  logic signed [A_W-1:0]     a,
    input  logic signed [B_W-1:0]     b,
    output logic signed [A_W+B_W-1:0] p
);

    localparam int P_W   = A_W + B_W;
    localparam int NA    = (A_W + LIMB_W - 1) / LIMB_W;
    localparam int NB    = (B_W + LIMB_W - 1) / LIMB_W;
    localparam int TOP_A = A_W - LIMB_W * (NA - 1);
    localparam int TOP_B = B_W - LIMB_W * (NB - 1);
    localparam int PP_W  = 2 * (LIMB_W + 1);
    localparam int EXT_W = P_W + PP_W;

    logic signed [LIMB_W:0]  a_limb [NA];
    logic signed [LIMB_W:0]  b_limb [NB];
    logic signed [PP_W-1:0]  pp_reg [NA][NB];
    logic [P_W-1:0]          row_next [NA];
    logic [P_W-1:0]          row_reg [NA];
    logic [P_W-1:0]          p_next;
    logic [P_W-1:0]          p_reg;

    // low limbs unsigned, top limb carries the sign
    for (genvar i = 0; i < NA; i++) begin : g_a
        if (i < NA - 1) begin : g_lo
            assign a_limb[i] = $signed({1'b0, a[LIMB_W*i +: LIMB_W]});
        end
        else begin : g_hi
            assign a_limb[i] = $signed({{(LIMB_W+1-TOP_A){a[A_W-1]}}, a[A_W-1:LIMB_W*i]});
        end
    end

    for (genvar j = 0; j < NB; j++) begin : g_b
        if (j < NB - 1) begin : g_lo
            assign b_limb[j] = $signed({1'b0, b[LIMB_W*j +: LIMB_W]});
        end
        else begin : g_hi
            assign b_limb[j] = $signed({{(LIMB_W+1-TOP_B){b[B_W-1]}}, b[B_W-1:LIMB_W*j]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_limb[i] * b_limb[j];
                end
            end
        end
    end

    // sums are taken modulo 2^P_W; the true product fits
    always_comb
    begin
        logic signed [EXT_W-1:0] ext;
        ext = '0;
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                ext         = EXT_W'(pp_reg[i][j]);
                row_next[i] = row_next[i] + (P_W'(ext) << (LIMB_W * j));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NA; i++)
            begin
                row_reg[i] <= row_next[i];
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            p_next = p_next + (row_reg[i] << (LIMB_W * i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg <= p_next;
        end
    end

    assign p = $signed(p_reg);

endmodule

`default_nettype wire

FILE: design/mcc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow precheck.
`timescale 1ns / 1ps
`default_nettype none

module mcc_div
    import mcc_pkg::*;
#(
    parameter int NUM_DW = NUM_W,
    parameter int DEN_DW = DET_W,
    parameter int Q_W    = COORD_W
)
(
    input  logic                     clk,
    input  logic                     adv,
    input  logic signed [NUM_DW-1:0] num,
    input  logic [DEN_DW-1:0]        den,
    input  logic                     den_neg,
    output logic [Q_W-1:0]           quo,
    output logic                     neg,
    output logic                     big
);

    localparam int CMP_W = (NUM_DW > DEN_DW + Q_W) ? NUM_DW : DEN_DW + Q_W;

    logic [NUM_DW-1:0] na_reg;
    logic [DEN_DW-1:0] da_reg;
    logic              neg_a_reg;

    logic [NUM_DW-1:0] rem_reg [Q_W+1];
    logic [DEN_DW-1:0] den_reg [Q_W+1];
    logic [Q_W-1:0]    q_reg   [Q_W+1];
    logic              neg_reg [Q_W+1];
    logic              big_reg [Q_W+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            na_reg    <= num[NUM_DW-1] ? $unsigned(-num) : $unsigned(num);
            da_reg    <= den;
            neg_a_reg <= num[NUM_DW-1] ^ den_neg;
        end
    end

    // quotient needs more than Q_W bits when |num| >= |den| * 2^Q_W
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= na_reg;
            den_reg[0] <= da_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_a_reg;
            big_reg[0] <= CMP_W'(na_reg) >= (CMP_W'(da_reg) << Q_W);
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int SH = Q_W - 1 - k;
        logic [CMP_W-1:0] sub_try;
        logic             fits;

        always_comb
        begin
            sub_try = CMP_W'(den_reg[k]) << SH;
            fits    = CMP_W'(rem_reg[k]) >= sub_try;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1] <= fits ? NUM_DW'(CMP_W'(rem_reg[k]) - sub_try) : rem_reg[k];
                q_reg[k+1]   <= q_reg[k] | (fits ? (Q_W'(1) << SH) : Q_W'(0));
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                big_reg[k+1] <= big_reg[k];
            end
        end
    end

    assign quo = q_reg[Q_W];
    assign neg = neg_reg[Q_W];
    assign big = big_reg[Q_W];

endmodule

`default_nettype wire

FILE: design/mcc_apb.sv
// APB register block holding the degeneracy threshold.
`timescale 1ns / 1ps
`default_nettype none

module mcc_apb
    import mcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [THR_W-1:0]      det_threshold
);

    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [THR_W-1:0]     thr_reg;
    logic [THR_W-1:0]     thr_next;

    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        thr_next = thr_reg;
        if (wr_en && (reg_idx == REG_DET_THRESHOLD))
        begin
            thr_next = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign prdata        = (reg_idx == REG_DET_THRESHOLD) ? CFG_DATA_W'(thr_reg) : '0;
    assign det_threshold = thr_reg;

endmodule

`default_nettype wire

FILE: design/metric_circumcenter_core.sv
// Metric circumcenter core: pipelined exact-fixed-point solver, top level.
//
// Usage: triangles (three Q16.16 vertices plus metric m11, m12, m22) arrive on
// in_ch, one transfer per cycle at most. Each produces one transfer on out_ch:
// circumcenter in Q16.16, a degenerate flag (zero coordinates) and an
// overflow flag (saturated coordinate). det_threshold is written over APB at
// byte address 0; the user must write it only while the core is idle, and the core leaves that to the user.
// Depth: 50 register ranks in the datapath, set by three 3-stage limb
// multiplier levels and the 34-stage bit-per-stage divider.
// Throughput: one triangle per cycle while out_ch.ready stays high.
// The whole pipeline advances together; in_ch.ready is high whenever the
// output register is empty or being taken, so a new triangle is accepted while
// the pipeline still holds earlier ones. When the receiver holds out_ch.ready
// low with a result waiting, every stage holds its item and in_ch.ready drops.
// Reset clears all valid bits and sets det_threshold to 1; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module metric_circumcenter_core
    import mcc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mcc_in_if.sink                in_ch,
    mcc_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // stage numbers of the register ranks
    localparam int S_L1  = 1;
    localparam int S_X   = S_L1 + MUL_LAT + 1;
    localparam int S_E   = S_X + MUL_LAT + 1;
    localparam int S_D   = S_E + 1;
    localparam int S_N   = S_D + MUL_LAT + 1;
    localparam int S_Q   = S_N + DIV_LAT;
    localparam int S_OUT = S_Q + 1;

    localparam int M_DLY  = S_X - S_L1;
    localparam int X_DLY  = S_D - S_X;
    localparam int DS_DLY = S_N - S_D;
    localparam int DG_N   = S_Q - S_D;

    logic               adv;
    logic [S_OUT:0]     v_reg;
    logic [THR_W-1:0]   thr;
    logic [DET_W-1:0]   thr_scaled;

    mcc_apb u_apb (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .det_threshold (thr)
    );

    assign adv         = !v_reg[S_OUT] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[S_OUT-1:0], in_ch.valid};
        end
    end

    // ---------------- stage 0: input capture
    logic signed [COORD_W-1:0] pt_s0_reg [6];
    logic signed [COORD_W-1:0] mt_s0_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_s0_reg[0] <= in_ch.ax;
            pt_s0_reg[1] <= in_ch.ay;
            pt_s0_reg[2] <= in_ch.bx;
            pt_s0_reg[3] <= in_ch.by_coord;
            pt_s0_reg[4] <= in_ch.cx;
            pt_s0_reg[5] <= in_ch.cy;
            mt_s0_reg[0] <= in_ch.metric_xx;
            mt_s0_reg[1] <= in_ch.metric_xy;
            mt_s0_reg[2] <= in_ch.metric_yy;
        end
    end

    // ---------------- stage 1: edge vectors
    logic signed [COORD_W-1:0] pt_s1_reg [6];
    logic signed [COORD_W-1:0] mt_s1_reg [3];
    logic signed [U_W-1:0]     u_s1_reg  [4];   // ux1, uy1, ux2, uy2

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_s1_reg   <= pt_s0_reg;
            mt_s1_reg   <= mt_s0_reg;
            u_s1_reg[0] <= U_W'(pt_s0_reg[2]) - U_W'(pt_s0_reg[0]);
            u_s1_reg[1] <= U_W'(pt_s0_reg[3]) - U_W'(pt_s0_reg[1]);
            u_s1_reg[2] <= U_W'(pt_s0_reg[4]) - U_W'(pt_s0_reg[0]);
            u_s1_reg[3] <= U_W'(pt_s0_reg[5]) - U_W'(pt_s0_reg[1]);
        end
    end

    // ---------------- multiplier level 1
    logic signed [COORD_W-1:0] l1_a [8];
    logic signed [U_W-1:0]     l1_b [8];
    logic signed [M1_W-1:0]    l1_p [8];

    // m11*ux1, m12*uy1, m22*uy1, m12*ux1, then the same for the C edge
    assign l1_a[0] = mt_s1_reg[0];  assign l1_b[0] = u_s1_reg[0];
    assign l1_a[1] = mt_s1_reg[1];  assign l1_b[1] = u_s1_reg[1];
    assign l1_a[2] = mt_s1_reg[2];  assign l1_b[2] = u_s1_reg[1];
    assign l1_a[3] = mt_s1_reg[1];  assign l1_b[3] = u_s1_reg[0];
    assign l1_a[4] = mt_s1_reg[0];  assign l1_b[4] = u_s1_reg[2];
    assign l1_a[5] = mt_s1_reg[1];  assign l1_b[5] = u_s1_reg[3];
    assign l1_a[6] = mt_s1_reg[2];  assign l1_b[6] = u_s1_reg[3];
    assign l1_a[7] = mt_s1_reg[1];  assign l1_b[7] = u_s1_reg[2];

    for (genvar k = 0; k < 8; k++) begin : g_l1
        mcc_mul #(.A_W(COORD_W), .B_W(U_W)) u_mul (
            .clk (clk),
            .adv (adv),
            .a   (l1_a[k]),
            .b   (l1_b[k]),
            .p   (l1_p[k])
        );
    end

    // per vertex: x*x, x*y, y*y
    logic signed [SQ_W-1:0] sq_p [9];

    for (genvar vv = 0; vv < 3; vv++) begin : g_sq
        mcc_mul #(.A_W(COORD_W), .B_W(COORD_W)) u_xx (
            .clk (clk), .adv (adv),
            .a   (pt_s1_reg[2*vv]), .b (pt_s1_reg[2*vv]),
            .p   (sq_p[3*vv])
        );
        mcc_mul #(.A_W(COORD_W), .B_W(COORD_W)) u_xy (
            .clk (clk), .adv (adv),
            .a   (pt_s1_reg[2*vv]), .b (pt_s1_reg[2*vv+1]),
            .p   (sq_p[3*vv+1])
        );
        mcc_mul #(.A_W(COORD_W), .B_W(COORD_W)) u_yy (
            .clk (clk), .adv (adv),
            .a   (pt_s1_reg[2*vv+1]), .b (pt_s1_reg[2*vv+1]),
            .p   (sq_p[3*vv+2])
        );
    end

    // metric entries ride along to the second multiplier level
    logic signed [COORD_W-1:0] m_dly_reg [M_DLY][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_dly_reg[0] <= mt_s1_reg;
            for (int i = 1; i < M_DLY; i++)
            begin
                m_dly_reg[i] <= m_dly_reg[i-1];
            end
        end
    end

    // ---------------- system coefficients
    logic signed [X_W-1:0]  xv_s5_reg [4];   // x12, x13, y12, y13
    logic signed [SQ_W-1:0] sq_s5_reg [9];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xv_s5_reg[0] <= (X_W'(l1_p[0]) + X_W'(l1_p[1])) << 1;
            xv_s5_reg[1] <= (X_W'(l1_p[4]) + X_W'(l1_p[5])) << 1;
            xv_s5_reg[2] <= (X_W'(l1_p[2]) + X_W'(l1_p[3])) << 1;
            xv_s5_reg[3] <= (X_W'(l1_p[6]) + X_W'(l1_p[7])) << 1;
            sq_s5_reg    <= sq_p;
        end
    end

    // ---------------- multiplier level 2
    logic signed [2*X_W-1:0] dp [2];
    logic signed [M2_W-1:0]  mp [9];

    mcc_mul #(.A_W(X_W), .B_W(X_W)) u_det0 (
        .clk (clk), .adv (adv),
        .a   (xv_s5_reg[0]), .b (xv_s5_reg[3]),
        .p   (dp[0])
    );
    mcc_mul #(.A_W(X_W), .B_W(X_W)) u_det1 (
        .clk (clk), .adv (adv),
        .a   (xv_s5_reg[1]), .b (xv_s5_reg[2]),
        .p   (dp[1])
    );

    for (genvar k = 0; k < 9; k++) begin : g_mn
        mcc_mul #(.A_W(COORD_W), .B_W(SQ_W)) u_mul (
            .clk (clk),
            .adv (adv),
            .a   (m_dly_reg[M_DLY-1][k % 3]),
            .b   (sq_s5_reg[k]),
            .p   (mp[k])
        );
    end

    logic signed [X_W-1:0] x_dly_reg [X_DLY][4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_dly_reg[0] <= xv_s5_reg;
            for (int i = 1; i < X_DLY; i++)
            begin
                x_dly_reg[i] <= x_dly_reg[i-1];
            end
        end
    end

    // ---------------- determinant and metric norms
    logic signed [DET_W-1:0] det_s9_reg;
    logic signed [K_W-1:0]   dk_s9_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_s9_reg <= DET_W'(dp[0]) - DET_W'(dp[1]);
            for (int i = 0; i < 3; i++)
            begin
                dk_s9_reg[i] <= K_W'(mp[3*i]) + (K_W'(mp[3*i+1]) << 1) + K_W'(mp[3*i+2]);
            end
        end
    end

    // ---------------- norm differences, |det|
    logic signed [E_W-1:0] d_s10_reg [2];
    logic [DET_W-1:0]      det_abs_s10_reg;
    logic                  det_neg_s10_reg;
    logic                  det_zero_s10_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_s10_reg[0]     <= E_W'(dk_s9_reg[1]) - E_W'(dk_s9_reg[0]);
            d_s10_reg[1]     <= E_W'(dk_s9_reg[2]) - E_W'(dk_s9_reg[0]);
            det_abs_s10_reg  <= det_s9_reg[DET_W-1] ? $unsigned(-det_s9_reg)
                                                    : $unsigned(det_s9_reg);
            det_neg_s10_reg  <= det_s9_reg[DET_W-1];
            det_zero_s10_reg <= (det_s9_reg == '0);
        end
    end

    // threshold sits at 2*FRAC_BITS fraction bits, det carries 4*FRAC_BITS
    assign thr_scaled = DET_W'(thr) << (2 * FRAC_BITS);

    logic dg_reg [DG_N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dg_reg[0] <= det_zero_s10_reg || (det_abs_s10_reg < thr_scaled);
            for (int i = 1; i < DG_N; i++)
            begin
                dg_reg[i] <= dg_reg[i-1];
            end
        end
    end

    logic [DET_W-1:0] ds_abs_dly_reg [DS_DLY];
    logic             ds_neg_dly_reg [DS_DLY];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_abs_dly_reg[0] <= det_abs_s10_reg;
            ds_neg_dly_reg[0] <= det_neg_s10_reg;
            for (int i = 1; i < DS_DLY; i++)
            begin
                ds_abs_dly_reg[i] <= ds_abs_dly_reg[i-1];
                ds_neg_dly_reg[i] <= ds_neg_dly_reg[i-1];
            end
        end
    end

    // ---------------- multiplier level 3: Cramer numerators
    logic signed [E_W-1:0]     l3_a [4];
    logic signed [X_W-1:0]     l3_b [4];
    logic signed [E_W+X_W-1:0] np   [4];

    // d1*y13, d2*y12, d2*x12, d1*x13
    assign l3_a[0] = d_s10_reg[0];  assign l3_b[0] = x_dly_reg[X_DLY-1][3];
    assign l3_a[1] = d_s10_reg[1];  assign l3_b[1] = x_dly_reg[X_DLY-1][2];
    assign l3_a[2] = d_s10_reg[1];  assign l3_b[2] = x_dly_reg[X_DLY-1][0];
    assign l3_a[3] = d_s10_reg[0];  assign l3_b[3] = x_dly_reg[X_DLY-1][1];

    for (genvar k = 0; k < 4; k++) begin : g_l3
        mcc_mul #(.A_W(E_W), .B_W(X_W)) u_mul (
            .clk (clk),
            .adv (adv),
            .a   (l3_a[k]),
            .b   (l3_b[k]),
            .p   (np[k])
        );
    end

    logic signed [NUM_W-1:0] n_s14_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_s14_reg[0] <= NUM_W'(np[0]) - NUM_W'(np[1]);
            n_s14_reg[1] <= NUM_W'(np[2]) - NUM_W'(np[3]);
        end
    end

    // ---------------- division
    logic [COORD_W-1:0] dv_q   [2];
    logic               dv_neg [2];
    logic               dv_big [2];

    for (genvar k = 0; k < 2; k++) begin : g_div
        mcc_div #(.NUM_DW(NUM_W), .DEN_DW(DET_W), .Q_W(COORD_W)) u_div (
            .clk     (clk),
            .adv     (adv),
            .num     (n_s14_reg[k]),
            .den     (ds_abs_dly_reg[DS_DLY-1]),
            .den_neg (ds_neg_dly_reg[DS_DLY-1]),
            .quo     (dv_q[k]),
            .neg     (dv_neg[k]),
            .big     (dv_big[k])
        );
    end

    // ---------------- saturation and output register
    logic [COORD_W-1:0] sat_val [2];
    logic               sat_ovf [2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (dv_neg[i])
            begin
                sat_ovf[i] = dv_big[i] || (dv_q[i] > SAT_MIN);
                sat_val[i] = sat_ovf[i] ? SAT_MIN : (-dv_q[i]);
            end
            else
            begin
                sat_ovf[i] = dv_big[i] || dv_q[i][COORD_W-1];
                sat_val[i] = sat_ovf[i] ? SAT_MAX : dv_q[i];
            end
        end
    end

    logic [COORD_W-1:0] cx_out_reg;
    logic [COORD_W-1:0] cy_out_reg;
    logic               degen_out_reg;
    logic               ovf_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_out_reg    <= dg_reg[DG_N-1] ? '0 : sat_val[0];
            cy_out_reg    <= dg_reg[DG_N-1] ? '0 : sat_val[1];
            degen_out_reg <= dg_reg[DG_N-1];
            ovf_out_reg   <= !dg_reg[DG_N-1] && (sat_ovf[0] || sat_ovf[1]);
        end
    end

    assign out_ch.valid      = v_reg[S_OUT];
    assign out_ch.center_x   = $signed(cx_out_reg);
    assign out_ch.center_y   = $signed(cy_out_reg);
    assign out_ch.degenerate = degen_out_reg;
    assign out_ch.overflow   = ovf_out_reg;

    // ---------------- checks
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.degenerate |->
            (cx_out_reg == '0) && (cy_out_reg == '0) && !out_ch.overflow)
        else $error("degenerate result with nonzero payload");

    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.overflow |->
            (cx_out_reg == SAT_MAX) || (cx_out_reg == SAT_MIN) ||
            (cy_out_reg == SAT_MAX) || (cy_out_reg == SAT_MIN))
        else $error("overflow flagged without a saturated coordinate");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(v_reg))
        else $error("pipeline moved while output stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input transfer possible while output stalled");

endmodule

`default_nettype wire
